// File: hw/rtl/rcrc_pkg.sv
package rcrc_pkg;

    localparam int TIME_BITS = 48;
    localparam int FRAC_BITS = 16;
    localparam int RATE_BITS = 18 + FRAC_BITS;
    localparam int CNT_BITS  = 32;

    localparam logic [FRAC_BITS:0] Q_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] Q_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS:0] LOSS_LIMIT = (FRAC_BITS + 1)'((64'd1 << FRAC_BITS) / 10);
    localparam logic [FRAC_BITS-1:0] W_MIN = FRAC_BITS'(((64'd1 << FRAC_BITS) + 50) / 100);

    localparam logic [31:0] RESET_RTT     = 32'd100000;
    localparam logic [16:0] RESET_NOMINAL = 17'd10000;
    localparam logic [31:0] RESET_SCALE   = 32'd20752;

    localparam logic [1:0] REG_RTT     = 2'd0;
    localparam logic [1:0] REG_NOMINAL = 2'd1;
    localparam logic [1:0] REG_SCALE   = 2'd2;

    // Divider width: dividend up to 34 + FRAC_BITS bits, divisor up to RATE_BITS.
    localparam int DIV_N = 34 + FRAC_BITS;
    localparam int DIV_D = RATE_BITS;
    localparam int DIV_CW = $clog2(DIV_N + 1);

    // Multiplier: rate width plus four bits by a Q1.F factor, one bit per cycle.
    localparam int MUL_A = RATE_BITS + 4;
    localparam int MUL_B = FRAC_BITS + 1;
    localparam int MUL_CW = $clog2(MUL_B + 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] poll_tick;
        logic                 pkt_valid;
        logic [31:0]          pkt_seq;
        logic                 pkt_end;
    } rcrc_in_t;

    typedef struct packed {
        logic        credit_valid;
        logic [31:0] credit_seq;
        logic [31:0] expected_seq;
        logic [17:0] rate_mbps;
        logic        late_packet;
        logic        feedback_done;
    } rcrc_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT_DIV,
        ST_INIT_WAIT,
        ST_CREDIT,
        ST_PKT,
        ST_FB_CHECK,
        ST_LOSS_WAIT,
        ST_BRANCH,
        ST_INC_M1_WAIT,
        ST_INC_M2_WAIT,
        ST_DEC_M1_WAIT,
        ST_DEC_M2_WAIT,
        ST_DEC_DIV_WAIT,
        ST_CLAMP,
        ST_IV_WAIT,
        ST_OUT
    } rcrc_state_t;

    typedef struct packed {
        logic start;
    } rcrc_go_t;

endpackage

// File: hw/rtl/receiver_credit_rate_controller.sv
// Channel   | Handshake            | Payload
// s_        | s_valid / s_ready    | s_data  (rcrc_in_t: poll)
// m_        | m_valid / m_ready    | m_data  (rcrc_out_t: result)
// cfg_      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A poll without feedback is worked through the credit, packet, feedback-check
// and output states. A feedback poll is set by the bit-serial divider and
// multiplier: a rate decrease takes three divisions and one product, and an
// increase three divisions and three products. After reset the initial credit
// interval is found by one division, during which no item is accepted. One item
// is worked at a time; a result waits in the output register while the next
// item is worked, and a second finished result holds off the input until the
// first is taken.
module receiver_credit_rate_controller
    import rcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rcrc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rcrc_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rcrc_state_t state_reg, state_next;

    logic [31:0] rtt_reg, scale_reg;
    logic [16:0] nominal_reg;

    logic [31:0]          expected_reg, expected_next;
    logic [31:0]          credit_num_reg, credit_num_next;
    logic                 sending_reg, sending_next;
    logic [TIME_BITS-1:0] last_credit_reg, last_credit_next;
    logic [31:0]          interval_reg, interval_next;
    logic [TIME_BITS-1:0] last_fb_reg, last_fb_next;
    logic [FRAC_BITS-1:0] weight_reg, weight_next;
    logic [RATE_BITS-1:0] rate_reg, rate_next;
    logic                 inc_reg, inc_next;
    logic [31:0]          sent_reg, sent_next;
    logic [31:0]          lost_reg, lost_next;

    rcrc_in_t  item_reg, item_next;
    rcrc_out_t res_reg, res_next;
    rcrc_out_t out_reg, out_next;
    logic      pend_reg, pend_next;
    logic      outv_reg, outv_next;
    logic [RATE_BITS+3:0] r_reg, r_next;
    logic [FRAC_BITS:0]   loss_reg, loss_next;

    rcrc_go_t          div_go, mul_go;
    logic [DIV_N-1:0]  div_a;
    logic [DIV_D-1:0]  div_b;
    logic              div_busy;
    logic [DIV_N-1:0]  div_q;
    logic [MUL_A-1:0]  mul_a;
    logic [MUL_B-1:0]  mul_b;
    logic              mul_busy;
    logic [MUL_A+MUL_B-1:0] mul_p;

    rcrc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .go(div_go), .dividend(div_a),
        .divisor(div_b), .busy(div_busy), .quotient(div_q)
    );

    rcrc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .go(mul_go), .a(mul_a), .b(mul_b),
        .busy(mul_busy), .product(mul_p)
    );

    logic [TIME_BITS-1:0] credit_gap, fb_gap;
    logic [32:0]          lost_sum;
    logic [32:0]          sent_sum;
    logic [RATE_BITS-1:0] nominal_q, floor_q;
    logic [RATE_BITS+3:0] target_q;
    logic [31:0]          q_sat;

    assign nominal_q = RATE_BITS'(nominal_reg) << FRAC_BITS;
    assign floor_q = nominal_q >> 1;
    assign q_sat = (|div_q[DIV_N-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];

    assign s_ready = (state_reg == ST_IDLE) && !pend_reg;
    assign cfg_ready = 1'b1;
    assign m_valid = outv_reg;
    assign m_data = out_reg;

    always_comb begin
        state_next = state_reg;
        expected_next = expected_reg;
        credit_num_next = credit_num_reg;
        sending_next = sending_reg;
        last_credit_next = last_credit_reg;
        interval_next = interval_reg;
        last_fb_next = last_fb_reg;
        weight_next = weight_reg;
        rate_next = rate_reg;
        inc_next = inc_reg;
        sent_next = sent_reg;
        lost_next = lost_reg;
        item_next = item_reg;
        res_next = res_reg;
        out_next = out_reg;
        pend_next = pend_reg;
        outv_next = outv_reg;
        r_next = r_reg;
        loss_next = loss_reg;
        div_go.start = 1'b0;
        mul_go.start = 1'b0;
        div_a = '0;
        div_b = '0;
        mul_a = '0;
        mul_b = '0;
        credit_gap = item_reg.poll_tick - last_credit_reg;
        fb_gap = item_reg.poll_tick - last_fb_reg;
        lost_sum = 33'(lost_reg) + 33'(item_reg.pkt_seq - expected_reg);
        sent_sum = 33'(sent_reg) + 33'd1;
        target_q = '0;

        if (outv_reg && m_ready) begin
            outv_next = 1'b0;
        end
        if (pend_reg && (!outv_reg || m_ready)) begin
            outv_next = 1'b1;
            out_next = res_reg;
            pend_next = 1'b0;
        end

        case (state_reg)
            ST_INIT_DIV: begin
                div_go.start = 1'b1;
                div_a = DIV_N'({scale_reg, 1'b0}) << FRAC_BITS;
                div_b = nominal_q;
                state_next = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (!div_busy) begin
                    interval_next = (nominal_reg == '0) ? 32'hFFFF_FFFF : q_sat;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    state_next = ST_CREDIT;
                end
            end
            ST_CREDIT: begin
                res_next = '0;
                if (sending_reg && (credit_gap > TIME_BITS'(interval_reg))) begin
                    sent_next = sent_sum[32] ? 32'hFFFF_FFFF : sent_sum[31:0];
                    credit_num_next = credit_num_reg + 32'd1;
                    last_credit_next = item_reg.poll_tick;
                    res_next.credit_valid = 1'b1;
                    res_next.credit_seq = credit_num_reg + 32'd1;
                end
                state_next = ST_PKT;
            end
            ST_PKT: begin
                if (item_reg.pkt_valid) begin
                    if (item_reg.pkt_end) begin
                        sending_next = 1'b0;
                    end
                    if (item_reg.pkt_seq == expected_reg) begin
                        expected_next = expected_reg + 32'd1;
                    end else if (item_reg.pkt_seq > expected_reg) begin
                        lost_next = lost_sum[32] ? 32'hFFFF_FFFF : lost_sum[31:0];
                        credit_num_next = expected_reg;
                    end else begin
                        res_next.late_packet = 1'b1;
                    end
                end
                state_next = ST_FB_CHECK;
            end
            ST_FB_CHECK: begin
                if (fb_gap > TIME_BITS'(rtt_reg)) begin
                    res_next.feedback_done = 1'b1;
                    last_fb_next = item_reg.poll_tick;
                    div_go.start = 1'b1;
                    div_a = DIV_N'(lost_reg) << FRAC_BITS;
                    div_b = DIV_D'(sent_reg);
                    state_next = ST_LOSS_WAIT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_LOSS_WAIT: begin
                if (!div_busy) begin
                    if (sent_reg == '0) begin
                        loss_next = '0;
                    end else if (div_q > DIV_N'(Q_ONE)) begin
                        loss_next = Q_ONE;
                    end else begin
                        loss_next = div_q[FRAC_BITS:0];
                    end
                    state_next = ST_BRANCH;
                end
            end
            ST_BRANCH: begin
                mul_go.start = 1'b1;
                if (loss_reg <= LOSS_LIMIT) begin
                    if (inc_reg) begin
                        weight_next = FRAC_BITS'(({1'b0, weight_reg} + {1'b0, Q_HALF}) >> 1);
                    end
                    mul_a = MUL_A'(rate_reg);
                    mul_b = Q_ONE - MUL_B'(inc_reg ?
                        FRAC_BITS'(({1'b0, weight_reg} + {1'b0, Q_HALF}) >> 1) : weight_reg);
                    inc_next = 1'b1;
                    state_next = ST_INC_M1_WAIT;
                end else begin
                    mul_a = MUL_A'(rate_reg);
                    mul_b = Q_ONE - loss_reg;
                    if (weight_reg < W_MIN) begin
                        weight_next = W_MIN;
                    end
                    inc_next = 1'b0;
                    state_next = ST_DEC_M1_WAIT;
                end
            end
            ST_INC_M1_WAIT: begin
                if (!mul_busy && !mul_go.start) begin
                    r_next = (RATE_BITS + 4)'(mul_p >> FRAC_BITS);
                    // Target is floor(1.1 * nominal) in Q form.
                    mul_go.start = 1'b1;
                    mul_a = MUL_A'(nominal_q) * MUL_A'(11);
                    mul_b = MUL_B'(1);
                    state_next = ST_INC_M2_WAIT;
                    r_next[RATE_BITS+3] = 1'b0;
                end
            end
            ST_INC_M2_WAIT: begin
                // First pass obtains 11*nominal; divide by 10 then weight.
                if (!mul_busy) begin
                    div_go.start = 1'b1;
                    div_a = DIV_N'(mul_p);
                    div_b = DIV_D'(10);
                    state_next = ST_DEC_DIV_WAIT;
                end
            end
            ST_DEC_M1_WAIT: begin
                if (!mul_busy) begin
                    div_go.start = 1'b1;
                    div_a = DIV_N'((mul_p >> FRAC_BITS) * 11);
                    div_b = DIV_D'(10);
                    state_next = ST_DEC_DIV_WAIT;
                end
            end
            ST_DEC_DIV_WAIT: begin
                if (!div_busy) begin
                    if (inc_reg) begin
                        // Quotient is the target; weight it and add.
                        target_q = (RATE_BITS + 4)'(div_q);
                        mul_go.start = 1'b1;
                        mul_a = MUL_A'(target_q);
                        mul_b = MUL_B'(weight_reg);
                        state_next = ST_DEC_M2_WAIT;
                    end else begin
                        r_next = (RATE_BITS + 4)'(div_q);
                        state_next = ST_CLAMP;
                    end
                end
            end
            ST_DEC_M2_WAIT: begin
                if (!mul_busy && !mul_go.start) begin
                    r_next = r_reg + (RATE_BITS + 4)'(mul_p >> FRAC_BITS);
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                if (r_reg > (RATE_BITS + 4)'({RATE_BITS{1'b1}})) begin
                    rate_next = {RATE_BITS{1'b1}};
                end else if (r_reg < (RATE_BITS + 4)'(floor_q)) begin
                    rate_next = floor_q;
                end else begin
                    rate_next = r_reg[RATE_BITS-1:0];
                end
                sent_next = '0;
                lost_next = '0;
                state_next = ST_IV_WAIT;
                div_go.start = 1'b1;
                div_a = DIV_N'(scale_reg) << FRAC_BITS;
                div_b = rate_next;
            end
            ST_IV_WAIT: begin
                if (!div_busy && !div_go.start) begin
                    interval_next = (rate_reg == '0) ? 32'hFFFF_FFFF : q_sat;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                res_next.expected_seq = expected_reg;
                res_next.rate_mbps = rate_reg[RATE_BITS-1:FRAC_BITS];
                pend_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg <= res_next;
        out_reg <= out_next;
        r_reg <= r_next;
        loss_reg <= loss_next;
        if (!aresetn) begin
            state_reg <= ST_INIT_DIV;
            rtt_reg <= RESET_RTT;
            nominal_reg <= RESET_NOMINAL;
            scale_reg <= RESET_SCALE;
            expected_reg <= '0;
            credit_num_reg <= '0;
            sending_reg <= 1'b1;
            last_credit_reg <= '0;
            interval_reg <= '0;
            last_fb_reg <= '0;
            weight_reg <= Q_HALF;
            rate_reg <= RATE_BITS'(RESET_NOMINAL) << FRAC_BITS;
            inc_reg <= 1'b1;
            sent_reg <= '0;
            lost_reg <= '0;
            pend_reg <= 1'b0;
            outv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            expected_reg <= expected_next;
            credit_num_reg <= credit_num_next;
            sending_reg <= sending_next;
            last_credit_reg <= last_credit_next;
            interval_reg <= interval_next;
            last_fb_reg <= last_fb_next;
            weight_reg <= weight_next;
            rate_reg <= rate_next;
            inc_reg <= inc_next;
            sent_reg <= sent_next;
            lost_reg <= lost_next;
            pend_reg <= pend_next;
            outv_reg <= outv_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RTT:     rtt_reg <= cfg_data;
                    REG_NOMINAL: nominal_reg <= cfg_data[16:0];
                    REG_SCALE:   scale_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // The rate never sits below half the nominal rate after a feedback.
    a_rate_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == ST_CLAMP) |-> (rate_reg >= floor_q))
        else $error("rate below floor");
    // A result only leaves the output register once the consumer takes it.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");
    // An accepted item starts in the credit state; no new item is taken while one is in progress.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CREDIT))
        else $error("item not started");

endmodule

// File: hw/rtl/rcrc_div.sv
module rcrc_div
    import rcrc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  rcrc_go_t          go,
    input  logic [DIV_N-1:0]  dividend,
    input  logic [DIV_D-1:0]  divisor,
    output logic              busy,
    output logic [DIV_N-1:0]  quotient
);

    // Restoring division, one quotient bit per cycle.
    logic [DIV_N-1:0]  q_reg, q_next;
    logic [DIV_D:0]    r_reg, r_next;
    logic [DIV_D-1:0]  d_reg, d_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DIV_D+1:0]  trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[DIV_N-1]} - {2'b00, d_reg};
        if (go.start) begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = DIV_CW'(DIV_N);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_D+1]) begin
                r_next = trial[DIV_D:0];
                q_next = {q_reg[DIV_N-2:0], 1'b1};
            end else begin
                r_next = {r_reg[DIV_D-1:0], q_reg[DIV_N-1]};
                q_next = {q_reg[DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = busy_reg;
    assign quotient = q_reg;

endmodule

// File: hw/rtl/rcrc_mul.sv
module rcrc_mul
    import rcrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rcrc_go_t              go,
    input  logic [MUL_A-1:0]      a,
    input  logic [MUL_B-1:0]      b,
    output logic                  busy,
    output logic [MUL_A+MUL_B-1:0] product
);

    // Shift-add multiplier, one multiplier bit per cycle.
    logic [MUL_A+MUL_B-1:0] acc_reg, acc_next;
    logic [MUL_A+MUL_B-1:0] a_reg, a_next;
    logic [MUL_B-1:0]       b_reg, b_next;
    logic [MUL_CW-1:0]      cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;

    always_comb begin
        acc_next = acc_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (go.start) begin
            acc_next = '0;
            a_next = (MUL_A + MUL_B)'(a);
            b_next = b;
            cnt_next = MUL_CW'(MUL_B);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next = a_reg << 1;
            b_next = b_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        b_reg <= b_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = busy_reg;
    assign product = acc_reg;

endmodule

// File: test/tb_receiver_credit_rate_controller.sv
`timescale 1ns / 100ps

module tb_receiver_credit_rate_controller;
    import rcrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;

    class credit_scoreboard;
        rcrc_out_t expected_q[$];
        int unsigned fails;

        bit [31:0] rtt, nominal, scale;
        bit [31:0] expected_num, credit_num, ivl, sent, lost;
        bit [47:0] last_credit_t, last_fb_t;
        bit [63:0] weight, rate;
        bit        sending, inc_phase;

        function new();
            fails = 0;
            rtt = RESET_RTT;
            nominal = 32'(RESET_NOMINAL);
            scale = RESET_SCALE;
            expected_num = 0;
            credit_num = 0;
            sending = 1;
            inc_phase = 1;
            last_credit_t = 0;
            last_fb_t = 0;
            weight = 64'(Q_HALF);
            rate = 64'(nominal) << FRAC_BITS;
            sent = 0;
            lost = 0;
            ivl = interval_of(64'(scale) * 2, rate);
        endfunction

        function bit [31:0] interval_of(bit [63:0] sc, bit [63:0] r);
            bit [63:0] q;
            if (r == 0) return 32'hFFFF_FFFF;
            q = (sc << FRAC_BITS) / r;
            return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        endfunction

        function bit [63:0] mul_frac(bit [63:0] a, bit [63:0] b);
            return (a >> FRAC_BITS) * b + (((a & (64'(Q_ONE) - 1)) * b) >> FRAC_BITS);
        endfunction

        function bit [31:0] sat_add(bit [31:0] a, bit [63:0] b);
            bit [63:0] s;
            s = 64'(a) + b;
            return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == REG_RTT) rtt = val;
            else if (idx == REG_NOMINAL) nominal = {15'd0, val[16:0]};
            else if (idx == REG_SCALE) scale = val;
        endfunction

        function void note_poll(rcrc_in_t p);
            rcrc_out_t o;
            bit [47:0] dt;
            bit [63:0] loss, r, target, floor_q;
            o = '0;
            dt = p.poll_tick - last_credit_t;
            if (sending && 64'(dt) > 64'(ivl)) begin
                sent = sat_add(sent, 64'd1);
                credit_num = credit_num + 32'd1;
                last_credit_t = p.poll_tick;
                o.credit_valid = 1;
                o.credit_seq = credit_num;
            end
            if (p.pkt_valid) begin
                if (p.pkt_end) sending = 0;
                if (p.pkt_seq == expected_num) begin
                    expected_num = expected_num + 32'd1;
                end else if (p.pkt_seq > expected_num) begin
                    lost = sat_add(lost, 64'(p.pkt_seq - expected_num));
                    credit_num = expected_num;
                end else begin
                    o.late_packet = 1;
                end
            end
            dt = p.poll_tick - last_fb_t;
            if (64'(dt) > 64'(rtt)) begin
                o.feedback_done = 1;
                last_fb_t = p.poll_tick;
                loss = 0;
                if (sent != 0) begin
                    loss = (64'(lost) << FRAC_BITS) / 64'(sent);
                    if (loss > 64'(Q_ONE)) loss = 64'(Q_ONE);
                end
                if (loss <= 64'(LOSS_LIMIT)) begin
                    target = ((64'(nominal) << FRAC_BITS) * 11) / 10;
                    if (inc_phase) weight = (weight + 64'(Q_HALF)) >> 1;
                    r = mul_frac(rate, 64'(Q_ONE) - weight) + mul_frac(target, weight);
                    inc_phase = 1;
                end else begin
                    r = mul_frac(rate, 64'(Q_ONE) - loss);
                    r = (r * 11) / 10;
                    if (weight < 64'(W_MIN)) weight = 64'(W_MIN);
                    inc_phase = 0;
                end
                if (r > (64'd1 << RATE_BITS) - 1) r = (64'd1 << RATE_BITS) - 1;
                floor_q = (64'(nominal) << FRAC_BITS) >> 1;
                if (r < floor_q) r = floor_q;
                rate = r;
                ivl = interval_of(64'(scale), rate);
                lost = 0;
                sent = 0;
            end
            o.expected_seq = expected_num;
            o.rate_mbps = rate[FRAC_BITS +: 18];
            expected_q.push_back(o);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            fails++;
        endtask

        task check_result(rcrc_out_t got);
            rcrc_out_t want;
            if (expected_q.size() == 0) begin
                report("unexpected result", 64'(got), 64'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.credit_valid !== want.credit_valid)
                report("credit_valid", 64'(got.credit_valid), 64'(want.credit_valid));
            if (got.credit_seq !== want.credit_seq)
                report("credit_seq", 64'(got.credit_seq), 64'(want.credit_seq));
            if (got.expected_seq !== want.expected_seq)
                report("expected_seq", 64'(got.expected_seq), 64'(want.expected_seq));
            if (got.rate_mbps !== want.rate_mbps)
                report("rate_mbps", 64'(got.rate_mbps), 64'(want.rate_mbps));
            if (got.late_packet !== want.late_packet)
                report("late_packet", 64'(got.late_packet), 64'(want.late_packet));
            if (got.feedback_done !== want.feedback_done)
                report("feedback_done", 64'(got.feedback_done), 64'(want.feedback_done));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    rcrc_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    rcrc_out_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    credit_scoreboard sb = new();
    int unsigned idle_cycles = 0;
    bit [47:0] tick_now = 0;

    receiver_credit_rate_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task send_poll(rcrc_in_t item);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_poll(item);
    endtask

    task write_cfg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Lower valid and wait until the block has drained every result.
    task drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task poll_at(bit [47:0] t, bit v, bit [31:0] seq, bit e);
        rcrc_in_t p;
        p.poll_tick = t;
        p.pkt_valid = v;
        p.pkt_seq = seq;
        p.pkt_end = e;
        tick_now = t;
        send_poll(p);
    endtask

    // Mostly in-order traffic with advancing time, some gaps, late and odd items.
    task random_poll(bit allow_end);
        rcrc_in_t p;
        int k;
        k = $urandom_range(0, 99);
        if (k < 65) tick_now = tick_now + $urandom_range(0, 40);
        else if (k < 80) tick_now = tick_now + sb.rtt + $urandom_range(0, 60);
        else if (k < 85) tick_now = 48'({$urandom, $urandom});
        else if (k < 90) tick_now = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 30);
        else tick_now = tick_now - $urandom_range(0, 20);
        p.poll_tick = tick_now;
        p.pkt_valid = 1'b1;
        p.pkt_end = 1'b0;
        k = $urandom_range(0, 99);
        if (k < 68) p.pkt_seq = sb.expected_num;
        else if (k < 80) p.pkt_seq = sb.expected_num + $urandom_range(1, 5);
        else if (k < 88) p.pkt_seq = sb.expected_num - $urandom_range(1, 5);
        else if (k < 93) p.pkt_seq = $urandom;
        else begin
            p.pkt_valid = 1'b0;
            p.pkt_seq = $urandom;
            p.pkt_end = 1'($urandom_range(0, 1));
        end
        if (allow_end && p.pkt_valid && $urandom_range(0, 49) == 0) p.pkt_end = 1'b1;
        send_poll(p);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_RTT;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed polls under the reset settings.
        poll_at(48'd0, 1'b0, 32'd0, 1'b0);
        poll_at(48'd4, 1'b1, 32'd0, 1'b0);
        poll_at(48'd5, 1'b1, 32'd1, 1'b0);
        poll_at(48'd20, 1'b1, 32'd5, 1'b0);
        poll_at(48'd40, 1'b1, 32'd0, 1'b0);
        poll_at(48'd100001, 1'b1, 32'd2, 1'b0);
        poll_at(48'd100010, 1'b1, 32'hFFFF_FFFF, 1'b0);
        poll_at(48'd300000, 1'b1, 32'd3, 1'b0);
        poll_at(48'hFFFF_FFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1);
        poll_at(48'd3, 1'b1, 32'd3, 1'b0);
        poll_at(48'd200000, 1'b1, 32'd4, 1'b0);
        poll_at(48'h8000_0000_0000, 1'b1, 32'd5, 1'b0);
        poll_at(48'h8000_0001_0000, 1'b1, 32'h7FFF_FFFF, 1'b0);
        poll_at(48'h8000_0002_0000, 1'b1, 32'd6, 1'b0);
        poll_at(48'h8000_0002_0000, 1'b1, 32'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    write_cfg(REG_RTT, 32'd0);
                    write_cfg(REG_NOMINAL, 32'd1);
                    write_cfg(REG_SCALE, 32'd1);
                end
                1: begin
                    write_cfg(REG_RTT, 32'hFFFF_FFFF);
                    write_cfg(REG_NOMINAL, 32'd100000);
                    write_cfg(REG_SCALE, 32'hFFFF_FFFF);
                end
                2: begin
                    write_cfg(REG_RTT, 32'd50);
                    write_cfg(REG_NOMINAL, 32'd100000);
                    write_cfg(REG_SCALE, 32'd1);
                end
                3: begin
                    write_cfg(REG_RTT, 32'd200);
                    write_cfg(REG_NOMINAL, 32'd1);
                    write_cfg(REG_SCALE, 32'hFFFF_FFFF);
                end
                6: begin
                    write_cfg(REG_RTT, RESET_RTT);
                    write_cfg(REG_NOMINAL, 32'(RESET_NOMINAL));
                    write_cfg(REG_SCALE, RESET_SCALE);
                end
                default: begin
                    write_cfg(REG_RTT, $urandom_range(0, 400));
                    write_cfg(REG_NOMINAL, $urandom_range(1, 100000));
                    write_cfg(REG_SCALE, $urandom_range(1, 32'h00FF_FFFF));
                end
            endcase
            for (int n = 0; n < 190; n++) begin
                if (phase == 2 && n == 95) drain();
                random_poll(phase == 6 && n > 120);
            end
            drain();
        end

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.fails == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
        end
    end

endmodule

// File: sim.f
hw/rtl/rcrc_pkg.sv
hw/rtl/rcrc_div.sv
hw/rtl/rcrc_mul.sv
hw/rtl/receiver_credit_rate_controller.sv
test/tb_receiver_credit_rate_controller.sv
